// ===== rtl/core/emdc_pkg.sv =====
// ----------------------------------------------------------------------------
// emdc_pkg
// shared types, codes and helpers for the end-stop motor drive controller
// ----------------------------------------------------------------------------
package emdc_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // command codes
    localparam logic [1:0] CMD_TO_MIN = 2'd0;
    localparam logic [1:0] CMD_TO_MAX = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    // motion state codes as reported
    localparam logic [1:0] MSTATE_IDLE   = 2'd0;
    localparam logic [1:0] MSTATE_TO_MIN = 2'd1;
    localparam logic [1:0] MSTATE_TO_MAX = 2'd2;
    localparam logic [1:0] MSTATE_FAULT  = 2'd3;

    // position codes
    localparam logic [1:0] LOC_MIN     = 2'd0;
    localparam logic [1:0] LOC_MAX     = 2'd1;
    localparam logic [1:0] LOC_UNKNOWN = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_BOTH    = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACT_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACT_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd5;

    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    typedef enum logic [3:0] {
        MO_IDLE   = 4'b0001,
        MO_TO_MIN = 4'b0010,
        MO_TO_MAX = 4'b0100,
        MO_FAULT  = 4'b1000
    } t_motion;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] command;
        logic       min_level;
        logic       max_level;
    } t_in_beat;

    typedef struct packed {
        logic       drive_a;
        logic       drive_b;
        logic [1:0] motion_state;
        logic [1:0] position;
        logic [1:0] status;
    } t_out_beat;

    typedef struct packed {
        logic        drive_mode;
        logic        min_stop_present;
        logic        max_stop_present;
        logic        min_active_high;
        logic        max_active_high;
        logic [31:0] timeout_ticks;
    } t_cfg;

    function automatic logic [1:0] motion_code(input t_motion m);
        logic [1:0] c;
        unique case (m)
            MO_IDLE:   c = MSTATE_IDLE;
            MO_TO_MIN: c = MSTATE_TO_MIN;
            MO_TO_MAX: c = MSTATE_TO_MAX;
            MO_FAULT:  c = MSTATE_FAULT;
            default:   c = MSTATE_IDLE;
        endcase
        return c;
    endfunction

    // effective stop activity; an absent stop reads as level 0
    function automatic logic stop_active(input logic present, input logic level,
                                         input logic act_high);
        logic lv;
        lv = present & level;
        return act_high ? lv : ~lv;
    endfunction

endpackage

// ===== rtl/core/emdc_engine.sv =====
// ----------------------------------------------------------------------------
// emdc_engine
// motion state, latched position, timeout counter and pin levels; one beat
// is applied per fire and its result is produced combinationally
// ----------------------------------------------------------------------------
module emdc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  emdc_pkg::t_in_beat  i_beat,
    input  emdc_pkg::t_cfg      i_cfg,
    output emdc_pkg::t_out_beat o_beat
);
    import emdc_pkg::*;

    t_motion     r_mode,  n_mode;
    logic [1:0]  r_loc,   n_loc;
    logic [31:0] r_el,    n_el;
    logic        r_prev_min, r_prev_max;
    logic        r_pin_a, n_pin_a;
    logic        r_pin_b, n_pin_b;

    logic min_now, max_now, min_was, max_was;
    logic min_tgt, max_tgt;
    logic [1:0] position, status;

    always_comb begin
        min_now = stop_active(i_cfg.min_stop_present, i_beat.min_level,
                              i_cfg.min_active_high);
        max_now = stop_active(i_cfg.max_stop_present, i_beat.max_level,
                              i_cfg.max_active_high);
        min_was = stop_active(i_cfg.min_stop_present, r_prev_min, i_cfg.min_active_high);
        max_was = stop_active(i_cfg.max_stop_present, r_prev_max, i_cfg.max_active_high);

        n_mode  = r_mode;
        n_loc   = r_loc;
        n_el    = r_el;
        n_pin_a = r_pin_a;
        n_pin_b = r_pin_b;

        // target stop edge ends the move
        if (r_mode == MO_TO_MIN && i_cfg.min_stop_present && min_now && !min_was) begin
            n_mode = MO_IDLE;
            n_loc  = LOC_MIN;
            n_el   = '0;
            if (!i_cfg.drive_mode) n_pin_a = 1'b0;
            n_pin_b = 1'b0;
        end else if (r_mode == MO_TO_MAX && i_cfg.max_stop_present && max_now
                     && !max_was) begin
            n_mode = MO_IDLE;
            n_loc  = LOC_MAX;
            n_el   = '0;
            if (!i_cfg.drive_mode) n_pin_a = 1'b0;
            n_pin_b = 1'b0;
        end

        min_tgt = min_now || (n_loc == LOC_MIN);
        max_tgt = max_now || (n_loc == LOC_MAX);

        unique case (i_beat.kind)
            KIND_TICK: begin
                if (n_mode == MO_TO_MIN || n_mode == MO_TO_MAX) begin
                    if (n_el != '1) n_el = n_el + 32'd1;
                    if (n_el > i_cfg.timeout_ticks) begin
                        n_mode = MO_FAULT;
                        n_loc  = LOC_UNKNOWN;
                        n_el   = '0;
                        if (!i_cfg.drive_mode) n_pin_a = 1'b0;
                        n_pin_b = 1'b0;
                    end
                end
            end
            KIND_CMD: begin
                // commands cut the drive first; reset or a new move clears a fault
                if (i_beat.command == CMD_RESET) begin
                    n_mode = MO_IDLE;
                    n_loc  = LOC_UNKNOWN;
                end else if (n_mode != MO_FAULT) begin
                    n_mode = MO_IDLE;
                end
                n_el = '0;
                if (!i_cfg.drive_mode) n_pin_a = 1'b0;
                n_pin_b = 1'b0;
                unique case (i_beat.command)
                    CMD_TO_MIN: begin
                        if (!min_tgt) begin
                            n_mode  = MO_TO_MIN;
                            n_loc   = LOC_UNKNOWN;
                            n_pin_a = !i_cfg.drive_mode;
                            n_pin_b = i_cfg.drive_mode;
                        end
                    end
                    CMD_TO_MAX: begin
                        if (!max_tgt) begin
                            n_mode  = MO_TO_MAX;
                            n_loc   = LOC_UNKNOWN;
                            n_pin_a = i_cfg.drive_mode;
                            n_pin_b = 1'b1;
                        end
                    end
                    CMD_STOP, CMD_RESET: begin
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        position = n_loc;
        status   = STAT_OK;
        if (i_beat.kind == KIND_STATUS) begin
            priority if (n_mode == MO_FAULT) begin
                status   = STAT_TIMEOUT;
                position = LOC_UNKNOWN;
            end else if ((min_now || n_loc == LOC_MIN) && (max_now || n_loc == LOC_MAX)) begin
                status   = STAT_BOTH;
                position = LOC_UNKNOWN;
            end else if (min_now || n_loc == LOC_MIN) begin
                position = LOC_MIN;
            end else if (max_now || n_loc == LOC_MAX) begin
                position = LOC_MAX;
            end else begin
                position = n_loc;
            end
        end

        o_beat.drive_a      = n_pin_a;
        o_beat.drive_b      = n_pin_b;
        o_beat.motion_state = motion_code(n_mode);
        o_beat.position     = position;
        o_beat.status       = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MO_IDLE;
            r_loc      <= LOC_UNKNOWN;
            r_el       <= '0;
            r_prev_min <= 1'b0;
            r_prev_max <= 1'b0;
            r_pin_a    <= 1'b0;
            r_pin_b    <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_loc      <= n_loc;
            r_el       <= n_el;
            r_prev_min <= i_beat.min_level;
            r_prev_max <= i_beat.max_level;
            r_pin_a    <= n_pin_a;
            r_pin_b    <= n_pin_b;
        end
    end

endmodule

// ===== rtl/core/endstop_motor_drive_controller_core.sv =====
// ----------------------------------------------------------------------------
// endstop_motor_drive_controller_core
// end-stop motor drive controller: input register, update engine, result
// register with valid/ready on both sides and a plain config write port
// ----------------------------------------------------------------------------
// Each input beat (tick, command or status read, plus the sampled end-stop
// levels) yields exactly one result beat carrying the pin levels, the motion
// state, the position and a status code. The block takes one beat per clock
// while results are taken: a beat lands in the input register, the engine
// applies it to the motion state combinationally and the result register
// captures its outcome when the beat advances; the sustained rate is one
// beat per cycle, set by the single state update of the engine per cycle.
// The input side keeps accepting while a result waits; it stalls only when
// both the input and result registers are full and the result is not taken.
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// and should only change while no beats are in flight.
// ----------------------------------------------------------------------------
module endstop_motor_drive_controller_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  emdc_pkg::t_in_beat                 i_in_beat,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output emdc_pkg::t_out_beat                o_out_beat,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [emdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [emdc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import emdc_pkg::*;

    // configuration registers
    t_cfg      r_cfg;

    // input register stage
    logic      r_in_valid;
    t_in_beat  r_in_beat;

    // result register stage
    logic      r_out_valid;
    t_out_beat r_out_beat;
    t_out_beat n_out_beat;

    logic      advance;
    logic      in_take;

    // the held beat moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_mode       <= 1'b0;
            r_cfg.min_stop_present <= 1'b0;
            r_cfg.max_stop_present <= 1'b0;
            r_cfg.min_active_high  <= 1'b1;
            r_cfg.max_active_high  <= 1'b1;
            r_cfg.timeout_ticks    <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DRIVE_MODE:  r_cfg.drive_mode       <= i_cfg_data[0];
                REG_MIN_PRESENT: r_cfg.min_stop_present <= i_cfg_data[0];
                REG_MAX_PRESENT: r_cfg.max_stop_present <= i_cfg_data[0];
                REG_MIN_ACT_HI:  r_cfg.min_active_high  <= i_cfg_data[0];
                REG_MAX_ACT_HI:  r_cfg.max_active_high  <= i_cfg_data[0];
                REG_TIMEOUT:     r_cfg.timeout_ticks    <= i_cfg_data[31:0];
                default: begin
                    // indexes past the register list are ignored
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_beat;
        end
    end

    // motion engine: state advances once per beat that moves to the result side
    emdc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_beat  (r_in_beat),
        .i_cfg   (r_cfg),
        .o_beat  (n_out_beat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // pin b is high only while a move is under way
    a_drive_matches_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.drive_b) |->
            (o_out_beat.motion_state == MSTATE_TO_MIN ||
             o_out_beat.motion_state == MSTATE_TO_MAX))
        else $error("drive pin b high without a move under way");

    // a timeout report always comes with a fault state and unknown position
    a_timeout_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == STAT_TIMEOUT) |->
            (o_out_beat.motion_state == MSTATE_FAULT &&
             o_out_beat.position == LOC_UNKNOWN))
        else $error("timeout status without fault state");

    // the input side only stalls when both stages are full and the result is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    // a beat taken into a free pipeline shows up as a result after passing the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !r_in_valid && !r_out_valid) |=> ##1 o_out_valid)
        else $error("result missing after accepted beat");

endmodule
